// File: rtl/erts_pkg.sv
// shared types and constants for the echo reply round trip statistics block
// no dependencies; used by the interfaces and all rtl modules
package erts_pkg;

   localparam logic signed [31:0] TRIP_NONE_MIN = 32'sd999999999;
   localparam logic [20:0] MICROS_PER_SECOND = 21'd1000000;
   localparam int DIV_STEPS = 48;
   localparam int DIV_CNT_W = 6;

   typedef struct packed {
      logic [3:0]  header_len_words;
      logic [15:0] packet_length;
      logic [7:0]  msg_type;
      logic [15:0] msg_ident;
      logic [15:0] msg_sequence;
      logic [31:0] sent_seconds;
      logic [19:0] sent_micros;
      logic [31:0] now_seconds;
      logic [19:0] now_micros;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] trip_micros;
      logic [31:0]        reply_total;
      logic signed [31:0] min_trip;
      logic signed [31:0] max_trip;
      logic signed [31:0] average_trip;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/erts_ifs.sv
// valid/ready channel interfaces for request, response and register write
// depends on erts_pkg for the payload types
interface erts_req_if;
   logic              valid;
   logic              ready;
   erts_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface erts_rsp_if;
   logic              valid;
   logic              ready;
   erts_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface erts_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/erts_trip.sv
// round trip arithmetic: seconds/microseconds difference, scale, clamp to 32-bit
// depends on erts_pkg
module erts_trip (
   input  logic               clock,
   input  logic               load,
   input  erts_pkg::req_type  item,
   output logic signed [31:0] trip
);

   logic signed [32:0] dsec;
   logic signed [20:0] dus;
   logic               borrow;
   logic signed [33:0] dsec_adj;
   logic signed [21:0] dus_adj;
   logic signed [54:0] prod_ff;
   logic signed [54:0] prod_in;
   logic signed [21:0] dus_ff;
   logic signed [21:0] dus_in;
   logic signed [55:0] total;
   logic               over_hi;
   logic               over_lo;

   assign dsec     = $signed({1'b0, item.now_seconds}) - $signed({1'b0, item.sent_seconds});
   assign dus      = $signed({1'b0, item.now_micros}) - $signed({1'b0, item.sent_micros});
   assign borrow   = dus[20];
   assign dsec_adj = {dsec[32], dsec} - $signed({33'd0, borrow});
   assign dus_adj  = {dus[20], dus}
                     + (borrow ? $signed({1'b0, erts_pkg::MICROS_PER_SECOND}) : 22'sd0);
   assign prod_in  = dsec_adj * $signed({1'b0, erts_pkg::MICROS_PER_SECOND});
   assign dus_in   = dus_adj;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         dus_ff  <= dus_in;
      end
   end

   assign total   = {prod_ff[54], prod_ff} + {{34{dus_ff[21]}}, dus_ff};
   // out of range when bits 31 and above are not all copies of the sign
   assign over_hi = !total[55] && (|total[54:31]);
   assign over_lo = total[55] && !(&total[54:31]);

   always_comb begin
      if (over_hi) begin
         trip = 32'sh7FFFFFFF;
      end else if (over_lo) begin
         trip = 32'sh80000000;
      end else begin
         trip = total[31:0];
      end
   end

endmodule

// File: rtl/erts_div.sv
// iterative restoring divider, one quotient bit per cycle, signed result clamped to 32 bits
// depends on erts_pkg
module erts_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [47:0]     dividend,
   input  logic [31:0]            divisor,
   output erts_pkg::div_stat_type stat,
   output logic signed [31:0]     quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           neg_ff, neg_in;
   logic [erts_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                    rem_ff, rem_in;
   logic [47:0]                    quo_ff, quo_in;
   logic [47:0]                    mag;
   logic [32:0]                    trial;
   logic [32:0]                    diff;
   logic                           fits;
   logic                           too_pos;
   logic                           too_neg;

   assign mag   = dividend[47] ? (~dividend + 48'd1) : dividend;
   assign trial = {rem_ff, quo_ff[47]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[47];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[46:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == erts_pkg::DIV_CNT_W'(erts_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // magnitude limits: 2^31 - 1 when positive, 2^31 when negative
   assign too_pos = |quo_ff[47:31];
   assign too_neg = (|quo_ff[47:32]) || (quo_ff[31] && (|quo_ff[30:0]));

   always_comb begin
      if (neg_ff) begin
         quotient = too_neg ? 32'sh80000000 : $signed(~quo_ff[31:0] + 32'd1);
      end else begin
         quotient = too_pos ? 32'sh7FFFFFFF : $signed(quo_ff[31:0]);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/echo_reply_rtt_statistics.sv
// top level: reply filter, sequencer, running statistics and result register
// depends on erts_pkg, erts_ifs, erts_trip and erts_div
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    erts_pkg::req_type (parsed header and timestamps)
//  rsp_ch    out  valid/ready    erts_pkg::rsp_type (flag, trip and statistics)
//  csr_ch    in   valid/ready    16-bit match identifier, always ready
//
// after the request transfer the sequencer runs the multiply, clamp and statistics update, then the
// 48-step divider for the average, and then presents the result
// while no reply has been counted the divide is skipped and the result follows the update
// a request is taken only while the sequencer is idle; the result register holds
// until its transfer, after which the next request is taken
// synchronous reset clears the statistics and the match identifier
module echo_reply_rtt_statistics (
   input logic        clock,
   input logic        reset,
   erts_req_if.sink   req_ch,
   erts_rsp_if.source rsp_ch,
   erts_csr_if.sink   csr_ch
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MULT   = 3'd1;
   localparam logic [2:0] ST_TRIP   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DSTART = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [15:0]            ident_ff, ident_in;
   erts_pkg::req_type      item_ff, item_in;
   logic                   ok_ff, ok_in;
   logic signed [31:0]     trip_ff, trip_in;
   logic [31:0]            count_ff, count_in;
   logic signed [31:0]     min_ff, min_in;
   logic signed [31:0]     max_ff, max_in;
   logic signed [47:0]     sum_ff, sum_in;
   logic signed [31:0]     avg_ff, avg_in;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   long_enough;
   logic                   ok_now;
   logic signed [31:0]     trip_calc;
   logic signed [48:0]     sum_ext;
   logic                   div_start;
   erts_pkg::div_stat_type div_stat;
   logic signed [31:0]     div_quo;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == ST_RESP);
   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // header bytes plus the 8 bytes of icmp header
   assign long_enough = {1'b0, req_ch.data.packet_length}
                        >= ({11'd0, req_ch.data.header_len_words, 2'b00} + 17'd8);
   assign ok_now = long_enough && (req_ch.data.msg_type == 8'd0)
                   && (req_ch.data.msg_ident == ident_ff)
                   && (req_ch.data.msg_sequence != 16'd0);

   erts_trip u_trip (
      .clock (clock),
      .load  (state_ff == ST_MULT),
      .item  (item_ff),
      .trip  (trip_calc)
   );

   erts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign sum_ext = {sum_ff[47], sum_ff} + {{17{trip_ff[31]}}, trip_ff};

   always_comb begin
      state_in  = state_ff;
      ident_in  = ident_ff;
      item_in   = item_ff;
      ok_in     = ok_ff;
      trip_in   = trip_ff;
      count_in  = count_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      avg_in    = avg_ff;
      div_start = 1'b0;
      if (csr_ch.valid) begin
         ident_in = csr_ch.data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_in  = req_ch.data;
               ok_in    = ok_now;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_TRIP;
         end
         ST_TRIP: begin
            trip_in  = ok_ff ? trip_calc : 32'sd0;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (ok_ff) begin
               if (count_ff != '1) begin
                  count_in = count_ff + 32'd1;
               end
               // saturate the sum when the carry disagrees with the sign
               if (sum_ext[48] != sum_ext[47]) begin
                  sum_in = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  sum_in = sum_ext[47:0];
               end
               if (trip_ff < min_ff) begin
                  min_in = trip_ff;
               end
               if (trip_ff > max_ff) begin
                  max_in = trip_ff;
               end
            end
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            if (count_ff == 32'd0) begin
               avg_in   = 32'sd0;
               state_in = ST_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               avg_in   = div_quo;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ident_ff <= 16'd0;
         count_ff <= 32'd0;
         min_ff   <= erts_pkg::TRIP_NONE_MIN;
         max_ff   <= 32'sd0;
         sum_ff   <= 48'sd0;
      end else begin
         state_ff <= state_in;
         ident_ff <= ident_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
      end
      item_ff <= item_in;
      ok_ff   <= ok_in;
      trip_ff <= trip_in;
      avg_ff  <= avg_in;
   end

   assign rsp_ch.data.accepted     = ok_ff;
   assign rsp_ch.data.trip_micros  = trip_ff;
   assign rsp_ch.data.reply_total  = count_ff;
   assign rsp_ch.data.min_trip     = min_ff;
   assign rsp_ch.data.max_trip     = max_ff;
   assign rsp_ch.data.average_trip = avg_ff;

`ifndef ASSERT_OFF
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ch.ready)
      else $error("request taken while a previous one is in progress");

   a_reject_zero_trip: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data.accepted) |-> (rsp_ch.data.trip_micros == 32'sd0))
      else $error("rejected packet reports a nonzero trip");

   a_min_not_above_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 32'd0) |-> (min_ff <= max_ff))
      else $error("minimum trip above maximum trip");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");
`endif

endmodule

// File: verif/erts_stats_checker.sv
`timescale 1ns / 100ps
// running statistics checker for the echo reply round trip block
// watches the request, result and identifier channels; depends on erts_pkg and erts_ifs
module erts_stats_checker #(
   parameter logic [7:0] REPLY_TYPE = 8'd0
) (
   input  logic clock,
   input  logic reset,
   erts_req_if  req_ch,
   erts_rsp_if  rsp_ch,
   erts_csr_if  csr_ch,
   output int   fail_count,
   output int   stats_waiting,
   output int   replies_counted
);
   import erts_pkg::*;

   localparam longint TRIP_HI = 64'sd2147483647;
   localparam longint TRIP_LO = -64'sd2147483648;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;

   logic [15:0]        own_ident;
   logic [31:0]        reply_cnt;
   logic signed [31:0] trip_low;
   logic signed [31:0] trip_high;
   logic signed [47:0] trip_total;
   rsp_type            expected_stats[$];
   int                 mismatch_cnt = 0;
   int                 accepted_cnt = 0;

   function automatic longint clamp_trip(input longint v);
      if (v > TRIP_HI) return TRIP_HI;
      if (v < TRIP_LO) return TRIP_LO;
      return v;
   endfunction

   // updates the running statistics and returns the result this packet should give
   function automatic rsp_type next_statistics(input req_type p);
      longint  dsec;
      longint  dus;
      longint  trip;
      longint  total;
      longint  avg;
      logic    ok;
      rsp_type r;
      ok = longint'(p.packet_length) >= 4 * longint'(p.header_len_words) + 8
           && p.msg_type == REPLY_TYPE && p.msg_ident == own_ident
           && p.msg_sequence != 16'd0;
      trip = 0;
      if (ok) begin
         dsec = longint'(p.now_seconds) - longint'(p.sent_seconds);
         dus = longint'(p.now_micros) - longint'(p.sent_micros);
         // one borrow only, micros above 999999 may leave dus negative
         if (dus < 0) begin
            dsec = dsec - 1;
            dus = dus + longint'(MICROS_PER_SECOND);
         end
         trip = clamp_trip(dsec * longint'(MICROS_PER_SECOND) + dus);
         if (reply_cnt != '1) reply_cnt = reply_cnt + 1;
         total = longint'(trip_total) + trip;
         if (total > SUM_HI) total = SUM_HI;
         if (total < SUM_LO) total = SUM_LO;
         trip_total = total[47:0];
         if (trip < longint'(trip_low)) trip_low = trip[31:0];
         if (trip > longint'(trip_high)) trip_high = trip[31:0];
      end
      avg = 0;
      if (reply_cnt != 0) avg = clamp_trip(longint'(trip_total) / longint'(reply_cnt));
      r.accepted = ok;
      r.trip_micros = trip[31:0];
      r.reply_total = reply_cnt;
      r.min_trip = trip_low;
      r.max_trip = trip_high;
      r.average_trip = avg[31:0];
      return r;
   endfunction

   task automatic report_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_cnt++;
   endtask

   task automatic compare_stats(input rsp_type want, input rsp_type got);
      if (want.accepted) accepted_cnt++;
      if (got.accepted !== want.accepted)
         report_field("accepted", want.accepted, got.accepted);
      if (got.trip_micros !== want.trip_micros)
         report_field("trip_micros", want.trip_micros, got.trip_micros);
      if (got.reply_total !== want.reply_total)
         report_field("reply_total", want.reply_total, got.reply_total);
      if (got.min_trip !== want.min_trip)
         report_field("min_trip", want.min_trip, got.min_trip);
      if (got.max_trip !== want.max_trip)
         report_field("max_trip", want.max_trip, got.max_trip);
      if (got.average_trip !== want.average_trip)
         report_field("average_trip", want.average_trip, got.average_trip);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         own_ident = '0;
         reply_cnt = '0;
         trip_low = TRIP_NONE_MIN;
         trip_high = '0;
         trip_total = '0;
         expected_stats.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) own_ident = csr_ch.data;
         // results first so a stray one never pairs with a request of the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: result transfer with nothing expected", $time);
               mismatch_cnt++;
            end else begin
               compare_stats(expected_stats.pop_front(), rsp_ch.data);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_stats.push_back(next_statistics(req_ch.data));
      end
      fail_count <= mismatch_cnt;
      stats_waiting <= expected_stats.size();
      replies_counted <= accepted_cnt;
   end

endmodule

// File: verif/echo_reply_rtt_statistics_tb.sv
`timescale 1ns / 100ps
// top of the echo reply round trip statistics testbench: clock, reset, packet stimulus
// and verdict; depends on erts_pkg, erts_ifs, the block and erts_stats_checker
module echo_reply_rtt_statistics_tb;
   import erts_pkg::*;

   localparam logic [7:0] ECHO_REPLY = 8'd0;
   localparam int RANDOM_PER_PHASE = 330;
   localparam int PHASES = 5;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_PCT = 38;

   logic clock;
   logic reset;

   erts_req_if req_ch ();
   erts_rsp_if rsp_ch ();
   erts_csr_if csr_ch ();

   int          fail_count;
   int          stats_waiting;
   int          replies_counted;
   int          sender_idle_pct = IDLE_PCT;
   int          packets_sent = 0;
   int          results_taken = 0;
   int          settings_used = 0;
   logic [15:0] ident_now = '0;

   echo_reply_rtt_statistics DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   erts_stats_checker #(.REPLY_TYPE(ECHO_REPLY)) stats_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .fail_count      (fail_count),
      .stats_waiting   (stats_waiting),
      .replies_counted (replies_counted)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stalls, one long hold-off, one stretch always ready
   initial begin : result_drain
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) results_taken++;
         if (results_taken == 700 && !held) begin
            held = 1'b1;
            hold = HOLD_OFF_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (results_taken >= 1000 && results_taken < 1250) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic req_type make_packet(input int hlen, input int plen, input int mtype,
                                           input int ident, input int seq,
                                           input logic [31:0] ssec, input logic [19:0] sus,
                                           input logic [31:0] nsec, input logic [19:0] nus);
      req_type p;
      p.header_len_words = 4'(hlen);
      p.packet_length = 16'(plen);
      p.msg_type = 8'(mtype);
      p.msg_ident = 16'(ident);
      p.msg_sequence = 16'(seq);
      p.sent_seconds = ssec;
      p.sent_micros = sus;
      p.now_seconds = nsec;
      p.now_micros = nus;
      return p;
   endfunction

   // mostly well-formed replies with random timing, the rest flawed or pure noise
   function automatic req_type random_packet(input logic [15:0] ident);
      req_type     p;
      int unsigned need;
      int unsigned pick;
      p.header_len_words = 4'($urandom_range(15));
      need = 4 * p.header_len_words + 8;
      if ($urandom_range(3) == 0) p.packet_length = 16'($urandom_range(65535, need));
      else p.packet_length = 16'($urandom_range(need + 60, need));
      p.msg_type = ECHO_REPLY;
      p.msg_ident = ident;
      p.msg_sequence = 16'($urandom_range(65535, 1));
      p.sent_seconds = $urandom;
      p.now_seconds = p.sent_seconds + $urandom_range(3);
      p.sent_micros = 20'($urandom_range(999999));
      p.now_micros = 20'($urandom_range(999999));
      pick = $urandom_range(99);
      if (pick < 8) begin
         p.sent_micros = 20'($urandom);
         p.now_micros = 20'($urandom);
      end else if (pick < 14) begin
         p.now_seconds = $urandom;
      end else if (pick >= 72) begin
         case (pick % 5)
            0: p.packet_length = 16'($urandom_range(need - 1));
            1: p.msg_type = 8'($urandom_range(255, 1));
            2: p.msg_ident = ident ^ 16'($urandom_range(65535, 1));
            3: p.msg_sequence = '0;
            default: begin
               p.header_len_words = 4'($urandom);
               p.packet_length = 16'($urandom);
               p.msg_type = 8'($urandom);
               p.msg_ident = 16'($urandom);
               p.msg_sequence = 16'($urandom);
               p.sent_seconds = $urandom;
               p.sent_micros = 20'($urandom);
               p.now_seconds = $urandom;
               p.now_micros = 20'($urandom);
            end
         endcase
      end
      return p;
   endfunction

   task automatic send_packet(input req_type p);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= p;
      do @(posedge clock); while (!req_ch.ready);
      packets_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (stats_waiting != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ident(input logic [15:0] v);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      ident_now = v;
      settings_used++;
   endtask

   initial begin : stimulus
      int m;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_ident(16'h0000);
      m = ident_now;
      // rejected first so the reset statistics show up
      send_packet(make_packet(0, 0, ECHO_REPLY, m, 0, 0, 0, 0, 0));
      // length boundaries
      send_packet(make_packet(0, 8, ECHO_REPLY, m, 1, 0, 0, 0, 0));
      send_packet(make_packet(5, 27, ECHO_REPLY, m, 7, 10, 0, 10, 250));
      send_packet(make_packet(15, 68, ECHO_REPLY, m, 2, 1000, 500, 1001, 1000));
      send_packet(make_packet(15, 67, ECHO_REPLY, m, 3, 1000, 500, 1001, 1000));
      send_packet(make_packet(15, 65535, ECHO_REPLY, m, 65535,
                              '1, 20'd999999, '1, 20'd999999));
      // wrong type, foreign identifier, first probe
      send_packet(make_packet(5, 84, 8, m, 4, 20, 0, 20, 7));
      send_packet(make_packet(5, 84, 255, m, 4, 20, 0, 20, 7));
      send_packet(make_packet(5, 84, ECHO_REPLY, m ^ 1, 4, 20, 0, 20, 7));
      send_packet(make_packet(5, 84, ECHO_REPLY, m ^ 16'hFFFF, 4, 20, 0, 20, 7));
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 0, 20, 0, 20, 7));
      // microsecond borrow, negative trips, out of range micros
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 5, 500, 20'd999999, 501, 0));
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 6, 100, 0, 99, 0));
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 7, 7, 20'hFFFFF, 7, 0));
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 8, 7, 0, 7, 20'hFFFFF));
      // clamp at both ends of the signed range
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 9, 0, 0, '1, 0));
      send_packet(make_packet(5, 84, ECHO_REPLY, m, 10, '1, 0, 0, 0));
      // all ones, counted and then with a non-reply type
      send_packet(make_packet(15, 65535, ECHO_REPLY, m, 65535, '1, 20'hFFFFF, '1, 20'hFFFFF));
      send_packet(make_packet(15, 65535, 255, 16'hFFFF, 65535, '1, 20'hFFFFF, '1, 20'hFFFFF));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 1) write_ident(16'hFFFF);
         else if (phase == 3) write_ident(16'h8000);
         else if (phase > 0) write_ident(16'($urandom));
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            sender_idle_pct = (phase == 1 && n >= 60 && n < 260) ? 0 : IDLE_PCT;
            send_packet(random_packet(ident_now));
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      $display("covered %0d packets, %0d counted as replies, under %0d identifier settings",
               packets_sent, replies_counted, settings_used);
      $display("results drained with random stalls and one hold-off of %0d cycles",
               HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/erts_pkg.sv
rtl/erts_ifs.sv
rtl/erts_trip.sv
rtl/erts_div.sv
rtl/echo_reply_rtt_statistics.sv
verif/erts_stats_checker.sv
verif/echo_reply_rtt_statistics_tb.sv
